// ===== rtl/cdt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdt_pkg: shared types and constants for the capacitance display text block
// Widths, thresholds, character codes and stage payload structs.
// ============================================================================
package cdt_pkg;

    localparam int CAP_W   = 24;              // input value width
    localparam int CHAR_W  = 7;               // ASCII character width
    localparam int DIG_N   = 8;               // decimal digits held in BCD
    localparam int BCD_W   = 4 * DIG_N;
    localparam int STEP_N  = 8;               // shift-add-3 steps per stage
    localparam int STAGE_N = CAP_W / STEP_N;  // conversion stages
    localparam int TEXT_N  = 10;              // longest text
    localparam int IDX_W   = $clog2(TEXT_N);

    // Index of the final character for each text kind.
    localparam logic [IDX_W-1:0] LAST_FIELD = IDX_W'(6);
    localparam logic [IDX_W-1:0] LAST_CALIB = IDX_W'(9);

    // Decade thresholds.
    localparam logic [CAP_W-1:0] LIM_10    = CAP_W'(10);
    localparam logic [CAP_W-1:0] LIM_100   = CAP_W'(100);
    localparam logic [CAP_W-1:0] LIM_1K    = CAP_W'(1000);
    localparam logic [CAP_W-1:0] LIM_10K   = CAP_W'(10000);
    localparam logic [CAP_W-1:0] LIM_100K  = CAP_W'(100000);
    localparam logic [CAP_W-1:0] LIM_1M    = CAP_W'(1000000);
    localparam logic [CAP_W-1:0] LIM_10M   = CAP_W'(10000000);
    localparam logic [CAP_W-1:0] LIM_CALIB = CAP_W'(16000000);

    // Display range codes.
    localparam logic [2:0] RNG_PF     = 3'd0;  // " ddd pF"
    localparam logic [2:0] RNG_NF_D2  = 3'd1;  // "d.dd nF"
    localparam logic [2:0] RNG_NF_D1  = 3'd2;  // "dd.d nF"
    localparam logic [2:0] RNG_NF_D0  = 3'd3;  // " ddd nF"
    localparam logic [2:0] RNG_UF_D2  = 3'd4;  // "d.dd uF"
    localparam logic [2:0] RNG_UF_D1  = 3'd5;  // "dd.d uF"
    localparam logic [2:0] RNG_CALIB  = 3'd6;  // "calibrate!"

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_F     = 7'h46;
    localparam logic [CHAR_W-1:0] CH_P     = 7'h70;
    localparam logic [CHAR_W-1:0] CH_N     = 7'h6E;
    localparam logic [CHAR_W-1:0] CH_U     = 7'h75;

    localparam logic [CHAR_W-1:0] CALIB_TEXT [TEXT_N] = '{
        7'h63, 7'h61, 7'h6C, 7'h69, 7'h62, 7'h72, 7'h61, 7'h74, 7'h65, 7'h21
    };

    // Payload of the binary to BCD stages.
    typedef struct packed {
        logic [CAP_W-1:0] bin;   // bits still to be shifted in
        logic [BCD_W-1:0] bcd;   // partial BCD result
        logic [CAP_W-1:0] cap;   // original value, for range selection
    } t_dab;

    // Finished text of one item.
    typedef struct packed {
        logic [TEXT_N-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]              last;
    } t_text;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] digit);
        return CH_ZERO + CHAR_W'(digit);
    endfunction

endpackage

// ===== rtl/cdt_dabble.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdt_dabble: one registered stage of the binary to BCD conversion
// Runs a fixed number of shift-and-add-3 steps and registers the result.
// ============================================================================
module cdt_dabble (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cdt_pkg::t_dab i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output cdt_pkg::t_dab o_data
);

    logic          r_valid;
    cdt_pkg::t_dab r_data;
    cdt_pkg::t_dab n_data;
    logic          load;

    // The register moves when it is empty or its content is being taken.
    assign load    = !r_valid || !i_stall;
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < cdt_pkg::STEP_N; s++) begin
            for (int k = 0; k < cdt_pkg::DIG_N; k++) begin
                if (n_data.bcd[4*k +: 4] >= 4'd5) begin
                    n_data.bcd[4*k +: 4] = n_data.bcd[4*k +: 4] + 4'd3;
                end
            end
            n_data.bcd = {n_data.bcd[cdt_pkg::BCD_W-2:0], n_data.bin[cdt_pkg::CAP_W-1]};
            n_data.bin = {n_data.bin[cdt_pkg::CAP_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== rtl/cdt_format.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdt_format: range selection and text layout stage
// Picks the range and places digits, point and unit, or the calibration text.
// ============================================================================
module cdt_format (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  cdt_pkg::t_dab  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output cdt_pkg::t_text o_text
);

    logic                                 r_valid;
    cdt_pkg::t_text                       r_text;
    cdt_pkg::t_text                       n_text;
    logic                                 load;
    logic [2:0]                           rng;
    logic [cdt_pkg::DIG_N-1:0][cdt_pkg::CHAR_W-1:0] dc;

    assign load    = !r_valid || !i_stall;
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_text  = r_text;

    always_comb begin
        if (i_data.cap >= cdt_pkg::LIM_CALIB) begin
            rng = cdt_pkg::RNG_CALIB;
        end else if (i_data.cap >= cdt_pkg::LIM_10M) begin
            rng = cdt_pkg::RNG_UF_D1;
        end else if (i_data.cap >= cdt_pkg::LIM_1M) begin
            rng = cdt_pkg::RNG_UF_D2;
        end else if (i_data.cap >= cdt_pkg::LIM_100K) begin
            rng = cdt_pkg::RNG_NF_D0;
        end else if (i_data.cap >= cdt_pkg::LIM_10K) begin
            rng = cdt_pkg::RNG_NF_D1;
        end else if (i_data.cap >= cdt_pkg::LIM_1K) begin
            rng = cdt_pkg::RNG_NF_D2;
        end else begin
            rng = cdt_pkg::RNG_PF;
        end
    end

    always_comb begin
        for (int k = 0; k < cdt_pkg::DIG_N; k++) begin
            dc[k] = cdt_pkg::to_ascii(i_data.bcd[4*k +: 4]);
        end
    end

    always_comb begin
        for (int k = 0; k < cdt_pkg::TEXT_N; k++) begin
            n_text.chars[k] = cdt_pkg::CH_SPACE;
        end
        n_text.chars[6] = cdt_pkg::CH_F;
        n_text.last     = cdt_pkg::LAST_FIELD;
        case (rng)
            cdt_pkg::RNG_PF: begin
                n_text.chars[1] = (i_data.cap >= cdt_pkg::LIM_100) ? dc[2] : cdt_pkg::CH_SPACE;
                n_text.chars[2] = (i_data.cap >= cdt_pkg::LIM_10) ? dc[1] : cdt_pkg::CH_SPACE;
                n_text.chars[3] = dc[0];
                n_text.chars[5] = cdt_pkg::CH_P;
            end
            cdt_pkg::RNG_NF_D2: begin
                n_text.chars[0] = dc[3];
                n_text.chars[1] = cdt_pkg::CH_DOT;
                n_text.chars[2] = dc[2];
                n_text.chars[3] = dc[1];
                n_text.chars[5] = cdt_pkg::CH_N;
            end
            cdt_pkg::RNG_NF_D1: begin
                n_text.chars[0] = dc[4];
                n_text.chars[1] = dc[3];
                n_text.chars[2] = cdt_pkg::CH_DOT;
                n_text.chars[3] = dc[2];
                n_text.chars[5] = cdt_pkg::CH_N;
            end
            cdt_pkg::RNG_NF_D0: begin
                n_text.chars[1] = dc[5];
                n_text.chars[2] = dc[4];
                n_text.chars[3] = dc[3];
                n_text.chars[5] = cdt_pkg::CH_N;
            end
            cdt_pkg::RNG_UF_D2: begin
                n_text.chars[0] = dc[6];
                n_text.chars[1] = cdt_pkg::CH_DOT;
                n_text.chars[2] = dc[5];
                n_text.chars[3] = dc[4];
                n_text.chars[5] = cdt_pkg::CH_U;
            end
            cdt_pkg::RNG_UF_D1: begin
                n_text.chars[0] = dc[7];
                n_text.chars[1] = dc[6];
                n_text.chars[2] = cdt_pkg::CH_DOT;
                n_text.chars[3] = dc[5];
                n_text.chars[5] = cdt_pkg::CH_U;
            end
            default: begin
                for (int k = 0; k < cdt_pkg::TEXT_N; k++) begin
                    n_text.chars[k] = cdt_pkg::CALIB_TEXT[k];
                end
                n_text.last = cdt_pkg::LAST_CALIB;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_text <= n_text;
        end
    end

endmodule

// ===== rtl/cdt_serial.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdt_serial: character serializer with output register
// Holds one finished text, sending one character per cycle unless stalled.
// ============================================================================
module cdt_serial (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  cdt_pkg::t_text             i_text,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cdt_pkg::CHAR_W-1:0] o_char,
    output logic                       o_last
);

    logic                          r_valid;
    cdt_pkg::t_text                r_buf;
    logic [cdt_pkg::IDX_W-1:0]     r_idx;
    logic                          r_out_valid;
    logic [cdt_pkg::CHAR_W-1:0]    r_out_char;
    logic                          r_out_last;
    logic                          load;
    logic                          emit;
    logic                          last_in_buf;
    logic                          free;
    logic                          take;

    assign load        = !r_out_valid || !i_stall;
    assign emit        = r_valid && load;
    assign last_in_buf = (r_idx == r_buf.last);
    // The buffer takes the next text in the cycle its final character leaves.
    assign free        = !r_valid || (emit && last_in_buf);
    assign take        = i_valid && free;
    assign o_stall     = !free;
    assign o_valid     = r_out_valid;
    assign o_char      = r_out_char;
    assign o_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_idx   <= '0;
            end else if (emit) begin
                r_valid <= !last_in_buf;
                r_idx   <= r_idx + cdt_pkg::IDX_W'(1);
            end
            if (load) begin
                r_out_valid <= r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_buf <= i_text;
        end
        if (emit) begin
            r_out_char <= r_buf.chars[r_idx];
            r_out_last <= last_in_buf;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_buf.last))
        else $error("serializer index beyond end of text");

    a_text_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_buf.last == cdt_pkg::LAST_FIELD || r_buf.last == cdt_pkg::LAST_CALIB))
        else $error("text length is neither seven nor ten characters");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last_in_buf) |=> (r_valid && r_idx == $past(r_idx) + cdt_pkg::IDX_W'(1)))
        else $error("serializer skipped or repeated a character");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_idx == $past(r_idx) || $past(take)))
        else $error("serializer advanced while the output was stalled");
`endif

endmodule

// ===== rtl/capacitance_to_display_text.sv =====
`timescale 1ns / 1ps
// ============================================================================
// capacitance_to_display_text: capacitance to seven- or ten-character text
// Converts a picofarad value to BCD, picks pF/nF/uF and streams the ASCII
// characters of the display field, one item per character.
// ============================================================================
//
//  Channel   Valid      Stall      Payload                     Direction
//  -------   --------   --------   -------------------------   ---------
//  input     i_valid    o_stall    i_cap_pf[23:0]              in
//  output    o_valid    i_stall    o_char_code[6:0], o_last_char  out
//
// An input item enters a three-stage binary to BCD pipeline (eight
// shift-and-add-3 steps per stage), then a layout stage, then the serializer.
// A value passes the conversion stage registers, the layout register, the
// serializer's text buffer and its output register on its way out.
// Each value then produces seven characters, or ten for "calibrate!", one per
// cycle while the output is not stalled; the serializer's single character
// port sets the sustained rate, with no gap between values.
// Reset is synchronous and active low; it clears the valid bits and r_idx.
// Stall from the output backs up stage by stage, and each stage keeps its
// item until the next one can take it, so nothing is lost or repeated.
//
module capacitance_to_display_text (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_cap_pf,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_char_code,
    output logic        o_last_char
);

    // Handshake and payload between the conversion stages; index zero is the
    // pipeline input and the last index feeds the layout stage.
    logic          dab_valid [cdt_pkg::STAGE_N+1];
    logic          dab_stall [cdt_pkg::STAGE_N+1];
    cdt_pkg::t_dab dab_data  [cdt_pkg::STAGE_N+1];

    logic           fmt_valid;
    logic           fmt_stall;
    cdt_pkg::t_text fmt_text;

    // The value enters with an empty BCD accumulator; the original value is
    // carried along so the layout stage can compare it against the decades.
    assign dab_valid[0]    = i_valid;
    assign o_stall         = dab_stall[0];
    assign dab_data[0].bin = i_cap_pf;
    assign dab_data[0].bcd = '0;
    assign dab_data[0].cap = i_cap_pf;

    genvar g;
    generate
        for (g = 0; g < cdt_pkg::STAGE_N; g++) begin : g_dab
            cdt_dabble u_dabble (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (dab_valid[g]),
                .o_stall (dab_stall[g]),
                .i_data  (dab_data[g]),
                .o_valid (dab_valid[g+1]),
                .i_stall (dab_stall[g+1]),
                .o_data  (dab_data[g+1])
            );
        end
    endgenerate

    // Range selection and character placement.
    cdt_format u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dab_valid[cdt_pkg::STAGE_N]),
        .o_stall (dab_stall[cdt_pkg::STAGE_N]),
        .i_data  (dab_data[cdt_pkg::STAGE_N]),
        .o_valid (fmt_valid),
        .i_stall (fmt_stall),
        .o_text  (fmt_text)
    );

    // One character per cycle unless stalled; the output register holds each one.
    cdt_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fmt_valid),
        .o_stall (fmt_stall),
        .i_text  (fmt_text),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_char  (o_char_code),
        .o_last  (o_last_char)
    );

endmodule

// ===== tb/capacitance_to_display_text_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// capacitance_to_display_text_tb: self-checking bench for the display text
// Drives picofarad values through the valid/stall input channel, predicts
// the ASCII characters of each display field, and checks every character
// that leaves the output channel against the oldest pending expectation.
// ============================================================================
module capacitance_to_display_text_tb;

    // Idle cycles with no item moving on either channel before giving up.
    // The slowest legal stretch is a stall burst and an input gap plus the
    // pipeline latency, so this limit is generous.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to watch the output after the last expected character, well
    // beyond the pipeline latency, so that stray characters show.
    localparam int DRAIN_CYCLES   = 40;
    // Once this few values are left to send, both sides stop idling.
    localparam int QUIET_TAIL     = 20;
    localparam int RANDOM_ITEMS   = 86;

    // Character codes used by the field layouts.
    localparam logic [cdt_pkg::CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [cdt_pkg::CHAR_W-1:0] ASCII_SPACE = 7'h20;
    localparam logic [cdt_pkg::CHAR_W-1:0] ASCII_DOT   = 7'h2E;
    localparam logic [cdt_pkg::CHAR_W-1:0] ASCII_F     = 7'h46;
    localparam logic [cdt_pkg::CHAR_W-1:0] ASCII_P     = 7'h70;
    localparam logic [cdt_pkg::CHAR_W-1:0] ASCII_N     = 7'h6E;
    localparam logic [cdt_pkg::CHAR_W-1:0] ASCII_U     = 7'h75;

    // One output character as it should appear on the output channel.
    typedef struct {
        logic [cdt_pkg::CHAR_W-1:0] code;
        logic                       last;
    } t_display_char;

    // Decade thresholds; entry k is the lower bound of decade k (k > 0) and
    // the last entry is the point where the block asks for calibration.
    int unsigned decade_bound [9] = '{
        1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 16000000
    };

    string calib_msg = "calibrate!";

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic [cdt_pkg::CAP_W-1:0]  i_cap_pf    = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic [cdt_pkg::CHAR_W-1:0] o_char_code;
    logic                       o_last_char;

    logic [cdt_pkg::CAP_W-1:0]  cap_values_pending [$];  // values still to be sent
    t_display_char              chars_expected [$];      // predicted characters in order
    int                         values_total = 0;
    int                         values_taken = 0;
    int                         errors       = 0;
    int                         send_gap     = 0;        // idle cycles left on the input
    int                         stall_left   = 0;        // stall cycles left on the output
    int                         idle_cycles  = 0;
    logic                       calm         = 1'b0;     // no idling in the final stretch

    capacitance_to_display_text dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cap_pf    (i_cap_pf),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ASCII code of the decimal digit of v at weight div, truncated.
    function automatic logic [cdt_pkg::CHAR_W-1:0] digit_char(input int unsigned v,
                                                              input int unsigned div);
        return ASCII_ZERO + cdt_pkg::CHAR_W'((v / div) % 10);
    endfunction

    // Builds the display text of one capacitance value and queues its
    // characters, the last one flagged, in the order they must leave.
    function automatic void queue_display_text(input logic [cdt_pkg::CAP_W-1:0] cap);
        int unsigned                v;
        logic [cdt_pkg::CHAR_W-1:0] txt [10];
        int                         n;
        int                         k;
        t_display_char              ch;
        v = cap;
        n = 7;
        txt[4] = ASCII_SPACE;
        txt[6] = ASCII_F;
        if (v >= 16000000) begin
            // Out of range: the whole ten-character request replaces the field.
            n = 10;
            for (k = 0; k < 10; k++) begin
                txt[k] = cdt_pkg::CHAR_W'(calib_msg[k]);
            end
        end else if (v < 1000) begin
            // Leading positions without a digit are blanks, never zeros.
            txt[0] = ASCII_SPACE;
            txt[1] = (v >= 100) ? digit_char(v, 100) : ASCII_SPACE;
            txt[2] = (v >= 10) ? digit_char(v, 10) : ASCII_SPACE;
            txt[3] = digit_char(v, 1);
            txt[5] = ASCII_P;
        end else if (v < 10000) begin
            txt[0] = digit_char(v, 1000);
            txt[1] = ASCII_DOT;
            txt[2] = digit_char(v, 100);
            txt[3] = digit_char(v, 10);
            txt[5] = ASCII_N;
        end else if (v < 100000) begin
            txt[0] = digit_char(v, 10000);
            txt[1] = digit_char(v, 1000);
            txt[2] = ASCII_DOT;
            txt[3] = digit_char(v, 100);
            txt[5] = ASCII_N;
        end else if (v < 1000000) begin
            txt[0] = ASCII_SPACE;
            txt[1] = digit_char(v, 100000);
            txt[2] = digit_char(v, 10000);
            txt[3] = digit_char(v, 1000);
            txt[5] = ASCII_N;
        end else if (v < 10000000) begin
            txt[0] = digit_char(v, 1000000);
            txt[1] = ASCII_DOT;
            txt[2] = digit_char(v, 100000);
            txt[3] = digit_char(v, 10000);
            txt[5] = ASCII_U;
        end else begin
            txt[0] = digit_char(v, 10000000);
            txt[1] = digit_char(v, 1000000);
            txt[2] = ASCII_DOT;
            txt[3] = digit_char(v, 100000);
            txt[5] = ASCII_U;
        end
        for (k = 0; k < n; k++) begin
            ch.code = txt[k];
            ch.last = (k == n - 1);
            chars_expected.push_back(ch);
        end
    endfunction

    // Input driver. A value is taken at an edge where i_valid is high and
    // o_stall is low; only then is its text predicted. The next value is
    // loaded in the same edge unless an idle burst is due, so back-to-back
    // values are offered without a bubble. i_valid is decided in a local
    // variable and written once per edge.
    always @(posedge i_clk) begin
        logic next_valid;
        next_valid = i_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                queue_display_text(i_cap_pf);
                values_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cap_values_pending.size() > 0) begin
                    if (cap_values_pending.size() > QUIET_TAIL &&
                        $urandom_range(0, 5) == 0) begin
                        // This cycle is idle too and is part of the burst.
                        send_gap = $urandom_range(0, 14);
                    end else begin
                        next_valid = 1'b1;
                        i_cap_pf <= cap_values_pending.pop_front();
                    end
                end
            end
        end
        i_valid <= next_valid;
        calm    <= (cap_values_pending.size() <= QUIET_TAIL);
    end

    // Output monitor. Each character taken from the output channel is
    // compared with the oldest prediction. The same block drives i_stall in
    // random bursts, which stop once the final stretch is reached.
    always @(posedge i_clk) begin
        logic          next_stall;
        t_display_char want;
        next_stall = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (chars_expected.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected character: expected none, got %h '%c' last %b",
                             $realtime, o_char_code, o_char_code, o_last_char);
                end else begin
                    want = chars_expected.pop_front();
                    if (o_char_code !== want.code) begin
                        errors++;
                        $display("%0t: char_code mismatch: expected %h '%c', got %h '%c'",
                                 $realtime, want.code, want.code, o_char_code, o_char_code);
                    end
                    if (o_last_char !== want.last) begin
                        errors++;
                        $display("%0t: last_char mismatch: expected %b, got %b",
                                 $realtime, want.last, o_last_char);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                next_stall = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 14);
                next_stall = 1'b1;
            end
        end
        i_stall <= next_stall;
    end

    // Watchdog: a run where neither channel moves for too long has hung,
    // for instance when characters were lost and expectations never drain.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no item moved for %0d cycles", $realtime, idle_cycles);
                    $display("capacitance_to_display_text test failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        int          dk;
        int          i;

        // Directed values: both ends of every decade, interior zeros that
        // must show as digits, the blank leading positions of the smallest
        // values, the edge of the calibration request and the largest input.
        cap_values_pending = '{
            24'd0, 24'd9, 24'd10, 24'd99, 24'd100, 24'd999,
            24'd1000, 24'd1005, 24'd9999, 24'd10000, 24'd10050, 24'd99999,
            24'd100000, 24'd100999, 24'd999999, 24'd1000000, 24'd1000500,
            24'd9999999, 24'd10000000, 24'd15999999, 24'd16000000,
            24'hFFFFFF, 24'hAAAAAA, 24'h555555
        };

        // Random values: mostly spread over the display ranges so that every
        // layout is hit often, plus values at the thresholds, out-of-range
        // values and fully random words that toggle every input bit.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 10);
            if (pick <= 7) begin
                lo = (pick == 0) ? 0 : decade_bound[pick];
                hi = decade_bound[pick + 1] - 1;
                cap_values_pending.push_back(cdt_pkg::CAP_W'($urandom_range(hi, lo)));
            end else if (pick == 8) begin
                dk = $urandom_range(1, 8);
                cap_values_pending.push_back(
                    cdt_pkg::CAP_W'(decade_bound[dk] - 1 + $urandom_range(0, 1)));
            end else if (pick == 9) begin
                cap_values_pending.push_back(
                    cdt_pkg::CAP_W'($urandom_range(24'hFFFFFF, 16000000)));
            end else begin
                cap_values_pending.push_back(cdt_pkg::CAP_W'($urandom));
            end
        end
        values_total = cap_values_pending.size();

        // Reset is held low from the start and released at a rising edge.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every value must be taken and every predicted character seen.
        while (values_taken < values_total || chars_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("capacitance_to_display_text test passed");
        end else begin
            $display("capacitance_to_display_text test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cdt_pkg.sv
rtl/cdt_dabble.sv
rtl/cdt_format.sv
rtl/cdt_serial.sv
rtl/capacitance_to_display_text.sv
tb/capacitance_to_display_text_tb.sv
